// File: sv/lmlt_pkg.sv
// ----------------------------------------------------------------------------
// lmlt_pkg
// Shared types, register codes and reset values for the LCD mode and line
// timing core.
// ----------------------------------------------------------------------------
package lmlt_pkg;

  localparam int CLK_W   = 11;
  localparam int LINE_W  = 8;
  localparam int CYC_W   = 10;
  localparam int ELAP_W  = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int LPF_W   = LINE_W + 1;

  localparam logic [CLK_W-1:0] CLOCK_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_CYCLES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OAM_END         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_LINES   = 3'd4;

  localparam logic [CYC_W-1:0]  RST_LINE_CYCLES     = 10'd456;
  localparam logic [CYC_W-1:0]  RST_OAM_END         = 10'd80;
  localparam logic [CYC_W-1:0]  RST_TRANSFER_END    = 10'd252;
  localparam logic [LINE_W-1:0] RST_LINES_PER_FRAME = 8'd154;
  localparam logic [LINE_W-1:0] RST_VISIBLE_LINES   = 8'd144;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CLK_W-1:0]  line_clock;
    logic [LINE_W-1:0] line_count;
    mode_t             mode;
    logic              coinc;
  } state_t;

  typedef struct packed {
    logic [CYC_W-1:0]  line_cycles;
    logic [CYC_W-1:0]  oam_end;
    logic [CYC_W-1:0]  transfer_end;
    logic [LPF_W-1:0]  lpf_eff;
    logic [LINE_W-1:0] visible_lines;
  } cfg_t;

  typedef struct packed {
    logic [ELAP_W-1:0] elapsed_clocks;
    logic [LINE_W-1:0] compare_line;
    logic              lyc_irq_enable;
    logic              oam_irq_enable;
    logic              vblank_irq_enable;
    logic              hblank_irq_enable;
  } in_word_t;

  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    mode_t             lcd_mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_line;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic              load_en;
    logic [LINE_W-1:0] load_val;
  } red_ctrl_t;

endpackage

// File: sv/lmlt_step.sv
// ----------------------------------------------------------------------------
// lmlt_step
// Combinational update of line clock, line counter, mode and coincidence
// flag for one input word, plus the result word.
// ----------------------------------------------------------------------------
module lmlt_step (
  input  lmlt_pkg::state_t                  st,
  input  logic [lmlt_pkg::LINE_W-1:0]       red,
  input  lmlt_pkg::cfg_t                    cfg,
  input  lmlt_pkg::in_word_t                din,
  output lmlt_pkg::state_t                  st_nxt,
  output logic                              line_end,
  output lmlt_pkg::out_word_t               dout
);
  import lmlt_pkg::*;

  logic [CLK_W:0]    sum;
  logic [CLK_W-1:0]  clk_sat;
  logic [LPF_W-1:0]  next_line;
  logic [LPF_W-1:0]  wrapped;
  logic [LINE_W-1:0] new_line;
  logic              vblank_irq;
  logic              stat_irq;
  logic              render;

  assign sum     = {1'b0, st.line_clock} + {{(CLK_W+1-ELAP_W){1'b0}}, din.elapsed_clocks};
  assign clk_sat = sum[CLK_W] ? CLOCK_MAX : sum[CLK_W-1:0];

  assign line_end = clk_sat >= {{(CLK_W-CYC_W){1'b0}}, cfg.line_cycles};

  // red is already below the frame length, so one subtract wraps it
  assign next_line = {1'b0, red} + {{(LPF_W-1){1'b0}}, 1'b1};
  assign wrapped   = (next_line >= cfg.lpf_eff) ? next_line - cfg.lpf_eff : next_line;
  assign new_line  = wrapped[LINE_W-1:0];

  always_comb begin
    st_nxt     = st;
    vblank_irq = 1'b0;
    stat_irq   = 1'b0;
    render     = 1'b0;
    st_nxt.line_clock = clk_sat;
    if (line_end) begin
      st_nxt.line_clock = clk_sat - {{(CLK_W-CYC_W){1'b0}}, cfg.line_cycles};
      st_nxt.line_count = new_line;
      st_nxt.coinc      = new_line == din.compare_line;
      if (st_nxt.coinc && din.lyc_irq_enable) begin
        stat_irq = 1'b1;
      end
      if (new_line == cfg.visible_lines) begin
        st_nxt.mode = MODE_VBLANK;
        vblank_irq  = 1'b1;
        if (din.vblank_irq_enable || din.oam_irq_enable) begin
          stat_irq = 1'b1;
        end
      end else if (new_line < cfg.visible_lines) begin
        st_nxt.mode = MODE_OAM;
        if (din.oam_irq_enable) begin
          stat_irq = 1'b1;
        end
      end
    end else if (st.mode == MODE_OAM &&
                 clk_sat >= {{(CLK_W-CYC_W){1'b0}}, cfg.oam_end}) begin
      st_nxt.mode = MODE_XFER;
    end else if (st.mode == MODE_XFER &&
                 clk_sat >= {{(CLK_W-CYC_W){1'b0}}, cfg.transfer_end}) begin
      st_nxt.mode = MODE_HBLANK;
      render      = 1'b1;
      if (din.hblank_irq_enable) begin
        stat_irq = 1'b1;
      end
    end
  end

  assign dout.current_line = st_nxt.line_count;
  assign dout.lcd_mode     = st_nxt.mode;
  assign dout.coincidence  = st_nxt.coinc;
  assign dout.vblank_irq   = vblank_irq;
  assign dout.stat_irq     = stat_irq;
  assign dout.render_line  = render;

endmodule

// File: sv/lmlt_line_reduce.sv
// ----------------------------------------------------------------------------
// lmlt_line_reduce
// Holds the line counter reduced modulo the frame length; after a frame
// length write it brings the stale counter back in range, one subtract a cycle.
// ----------------------------------------------------------------------------
module lmlt_line_reduce (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lmlt_pkg::red_ctrl_t               ctrl,
  input  logic [lmlt_pkg::LINE_W-1:0]       line_count,
  input  logic [lmlt_pkg::LPF_W-1:0]        lpf_eff,
  output logic [lmlt_pkg::LINE_W-1:0]       red,
  output logic                              busy
);
  import lmlt_pkg::*;

  logic [LINE_W-1:0] red_r, red_nxt;
  logic              busy_r, busy_nxt;
  logic [LPF_W-1:0]  diff;

  assign diff = {1'b0, red_r} - lpf_eff;

  always_comb begin
    red_nxt  = red_r;
    busy_nxt = busy_r;
    priority if (ctrl.start) begin
      red_nxt  = line_count;
      busy_nxt = 1'b1;
    end else if (ctrl.load_en) begin
      red_nxt = ctrl.load_val;
    end else if (busy_r && ({1'b0, red_r} >= lpf_eff)) begin
      red_nxt = diff[LINE_W-1:0];
    end else begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      red_r  <= red_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign red  = red_r;
  assign busy = busy_r;

endmodule

// File: sv/lcd_mode_line_timing_core.sv
// ----------------------------------------------------------------------------
// lcd_mode_line_timing_core
// LCD line clock, line counter, mode and coincidence sequencer.
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one word per step: elapsed clocks, line compare value and the
//   four stat interrupt enables. out_* returns one word per input word: line,
//   mode, coincidence flag and the vblank, stat and render pulses.
//   cfg_write_en/cfg_index/cfg_data write the five timing registers while the
//   core is idle; unknown indexes are ignored.
// pipeline and throughput:
//   an accepted word is held in the input register; its result is computed
//   by the update logic and registered in the output register, then shown
//   with out_valid. one word per cycle is sustained while neither out_stall
//   nor a line reduction holds the flow, set by the single step through the
//   update logic. a write of lines_per_frame holds in_stall while the line
//   counter is reduced by repeated subtraction.
// reset:
//   synchronous active-low rst_n restores register defaults, line 0, oam mode.
// stall:
//   while out_stall holds a result, one more word is taken into the input
//   register, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lmlt_pkg::ELAP_W-1:0]        in_elapsed_clocks,
  input  logic [lmlt_pkg::LINE_W-1:0]        in_compare_line,
  input  logic                               in_lyc_irq_enable,
  input  logic                               in_oam_irq_enable,
  input  logic                               in_vblank_irq_enable,
  input  logic                               in_hblank_irq_enable,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lmlt_pkg::LINE_W-1:0]        out_current_line,
  output logic [1:0]                         out_lcd_mode,
  output logic                               out_coincidence,
  output logic                               out_vblank_irq,
  output logic                               out_stat_irq,
  output logic                               out_render_line,
  input  logic                               cfg_write_en,
  input  logic [lmlt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmlt_pkg::CFG_W-1:0]         cfg_data
);
  import lmlt_pkg::*;

  logic [CYC_W-1:0]  line_cycles_r;
  logic [CYC_W-1:0]  oam_end_r;
  logic [CYC_W-1:0]  transfer_end_r;
  logic [LINE_W-1:0] lpf_r;
  logic [LINE_W-1:0] visible_lines_r;
  cfg_t              cfg;

  state_t    st_r, st_nxt;
  in_word_t  in_r;
  logic      in_valid_r;
  out_word_t out_r, dout;
  logic      out_valid_r;
  logic      line_end;
  logic      advance;
  logic      in_take;
  red_ctrl_t red_ctrl;
  logic [LINE_W-1:0] red;
  logic      red_busy;

  assign cfg.line_cycles   = line_cycles_r;
  assign cfg.oam_end       = oam_end_r;
  assign cfg.transfer_end  = transfer_end_r;
  assign cfg.lpf_eff       = (lpf_r == '0) ? {1'b1, {LINE_W{1'b0}}} : {1'b0, lpf_r};
  assign cfg.visible_lines = visible_lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cycles_r   <= RST_LINE_CYCLES;
      oam_end_r       <= RST_OAM_END;
      transfer_end_r  <= RST_TRANSFER_END;
      lpf_r           <= RST_LINES_PER_FRAME;
      visible_lines_r <= RST_VISIBLE_LINES;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_LINE_CYCLES:     line_cycles_r   <= cfg_data;
        CFG_OAM_END:         oam_end_r       <= cfg_data;
        CFG_TRANSFER_END:    transfer_end_r  <= cfg_data;
        CFG_LINES_PER_FRAME: lpf_r           <= cfg_data[LINE_W-1:0];
        CFG_VISIBLE_LINES:   visible_lines_r <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = red_busy || (in_valid_r && !advance);
  assign in_take  = in_valid && !in_stall;

  lmlt_step u_step (
    .st       (st_r),
    .red      (red),
    .cfg      (cfg),
    .din      (in_r),
    .st_nxt   (st_nxt),
    .line_end (line_end),
    .dout     (dout)
  );

  assign red_ctrl.start    = cfg_write_en && (cfg_index == CFG_LINES_PER_FRAME);
  assign red_ctrl.load_en  = advance && line_end;
  assign red_ctrl.load_val = st_nxt.line_count;

  lmlt_line_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (red_ctrl),
    .line_count (st_r.line_count),
    .lpf_eff    (cfg.lpf_eff),
    .red        (red),
    .busy       (red_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.line_clock <= '0;
      st_r.line_count <= '0;
      st_r.mode       <= MODE_OAM;
      st_r.coinc      <= 1'b0;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.elapsed_clocks    <= in_elapsed_clocks;
      in_r.compare_line      <= in_compare_line;
      in_r.lyc_irq_enable    <= in_lyc_irq_enable;
      in_r.oam_irq_enable    <= in_oam_irq_enable;
      in_r.vblank_irq_enable <= in_vblank_irq_enable;
      in_r.hblank_irq_enable <= in_hblank_irq_enable;
    end
    if (advance) begin
      out_r <= dout;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_current_line = out_r.current_line;
  assign out_lcd_mode     = out_r.lcd_mode;
  assign out_coincidence  = out_r.coincidence;
  assign out_vblank_irq   = out_r.vblank_irq;
  assign out_stat_irq     = out_r.stat_irq;
  assign out_render_line  = out_r.render_line;

  // no word enters while the line counter is being reduced
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    red_busy |-> in_stall)
    else $error("input taken during line reduction");

  a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.vblank_irq) |-> (out_r.lcd_mode == MODE_VBLANK))
    else $error("vblank pulse outside vblank mode");

  a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.render_line) |->
      (out_r.lcd_mode == MODE_HBLANK && !out_r.vblank_irq))
    else $error("render pulse outside hblank entry");

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && dout.vblank_irq) |-> (dout.current_line == visible_lines_r))
    else $error("vblank entered on wrong line");

  a_state_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_r.current_line == st_r.line_count && out_r.lcd_mode == st_r.mode))
    else $error("result word does not match state");

endmodule
